[sv/vt4_pkg.sv]
package vt4_pkg;

   // Field widths of the vector, the coefficients and the internal sums.
   localparam int CompW  = 16;
   localparam int CoeffW = 16;
   localparam int ProdW  = 32;
   localparam int SumW   = 34;
   localparam int FracShift = 12;
   localparam int ShiftW = SumW - FracShift;
   localparam int NumComp = 4;
   localparam int RowW   = NumComp * CoeffW;
   localparam int CsrIdxW = 3;

   localparam logic signed [SumW-1:0] RoundHalf = SumW'(2048);
   localparam logic signed [CompW-1:0] SatMax = 16'sh7FFF;
   localparam logic signed [CompW-1:0] SatMin = 16'sh8000;

   // Register indexes of the configuration port.
   typedef enum logic [CsrIdxW-1:0] {
      CSR_OUT_X = 3'd0,
      CSR_OUT_Y = 3'd1,
      CSR_OUT_Z = 3'd2,
      CSR_OUT_W = 3'd3
   } csr_index_type;

   // Reset values of the coefficient rows form the identity matrix.
   localparam logic [RowW-1:0] ResetOutX = 64'h0000_0000_0000_1000;
   localparam logic [RowW-1:0] ResetOutY = 64'h0000_0000_1000_0000;
   localparam logic [RowW-1:0] ResetOutZ = 64'h0000_1000_0000_0000;
   localparam logic [RowW-1:0] ResetOutW = 64'h1000_0000_0000_0000;

   typedef struct packed {
      logic signed [CompW-1:0] x_in;
      logic signed [CompW-1:0] y_in;
      logic signed [CompW-1:0] z_in;
      logic signed [CompW-1:0] w_in;
      logic                    last_in;
   } req_type;

   typedef struct packed {
      logic signed [CompW-1:0] x_out;
      logic signed [CompW-1:0] y_out;
      logic signed [CompW-1:0] z_out;
      logic signed [CompW-1:0] w_out;
      logic                    saturated;
      logic                    last_out;
   } rsp_type;

   // Load enables for the two register stages inside each lane.
   typedef struct packed {
      logic en_mul;
      logic en_sum;
   } lane_ctrl_type;

endpackage

[sv/vt4_lane.sv]
module vt4_lane (
   input  logic                                  clock,
   input  vt4_pkg::lane_ctrl_type                ctrl,
   input  vt4_pkg::req_type                      req,
   input  logic [vt4_pkg::RowW-1:0]              row,
   output logic signed [vt4_pkg::CompW-1:0]      result,
   output logic                                  clip
);

   logic signed [vt4_pkg::ProdW-1:0] vec_ext  [vt4_pkg::NumComp];
   logic signed [vt4_pkg::ProdW-1:0] coef_ext [vt4_pkg::NumComp];
   logic signed [vt4_pkg::ProdW-1:0] prod_in  [vt4_pkg::NumComp];
   logic signed [vt4_pkg::ProdW-1:0] prod_ff  [vt4_pkg::NumComp];
   logic signed [vt4_pkg::SumW-1:0]  prod_wide [vt4_pkg::NumComp];
   logic signed [vt4_pkg::SumW-1:0]  sum_in;
   logic signed [vt4_pkg::SumW-1:0]  sum_ff;
   logic signed [vt4_pkg::SumW-1:0]  rounded;
   logic signed [vt4_pkg::ShiftW-1:0] shifted;

   // Sign-extend the vector components and this row's coefficients, then multiply.
   always_comb begin
      vec_ext[0] = vt4_pkg::ProdW'(req.x_in);
      vec_ext[1] = vt4_pkg::ProdW'(req.y_in);
      vec_ext[2] = vt4_pkg::ProdW'(req.z_in);
      vec_ext[3] = vt4_pkg::ProdW'(req.w_in);
      for (int k = 0; k < vt4_pkg::NumComp; k++) begin
         coef_ext[k] = vt4_pkg::ProdW'($signed(row[k*vt4_pkg::CoeffW +: vt4_pkg::CoeffW]));
         prod_in[k]  = vec_ext[k] * coef_ext[k];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en_mul) begin
         for (int k = 0; k < vt4_pkg::NumComp; k++) begin
            prod_ff[k] <= prod_in[k];
         end
      end
   end

   // Sum the four products at full width.
   always_comb begin
      for (int k = 0; k < vt4_pkg::NumComp; k++) begin
         prod_wide[k] = vt4_pkg::SumW'(prod_ff[k]);
      end
      sum_in = prod_wide[0] + prod_wide[1] + prod_wide[2] + prod_wide[3];
   end

   always_ff @(posedge clock) begin
      if (ctrl.en_sum) begin
         sum_ff <= sum_in;
      end
   end

   // Round half up to Q8.8, then clip to the signed 16-bit range.
   always_comb begin
      rounded = sum_ff + vt4_pkg::RoundHalf;
      shifted = $signed(rounded[vt4_pkg::SumW-1:vt4_pkg::FracShift]);
      if (shifted > vt4_pkg::SatMax) begin
         result = vt4_pkg::SatMax;
         clip   = 1'b1;
      end else if (shifted < vt4_pkg::SatMin) begin
         result = vt4_pkg::SatMin;
         clip   = 1'b1;
      end else begin
         result = $signed(shifted[vt4_pkg::CompW-1:0]);
         clip   = 1'b0;
      end
   end

endmodule

[sv/vt4_merge.sv]
module vt4_merge (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           lanes_valid,
   input  logic                                           last,
   input  logic [vt4_pkg::NumComp-1:0][vt4_pkg::CompW-1:0] lane_result,
   input  logic [vt4_pkg::NumComp-1:0]                    lane_clip,
   input  logic                                           rsp_stall,
   output logic                                           ready,
   output logic                                           rsp_valid,
   output vt4_pkg::rsp_type                               rsp_data
);

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   vt4_pkg::rsp_type rsp_ff;
   vt4_pkg::rsp_type rsp_in;

   // The output register takes a new beat when it is empty or being drained.
   always_comb begin
      ready        = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = ready ? lanes_valid : rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (ready) begin
         rsp_in.x_out     = $signed(lane_result[0]);
         rsp_in.y_out     = $signed(lane_result[1]);
         rsp_in.z_out     = $signed(lane_result[2]);
         rsp_in.w_out     = $signed(lane_result[3]);
         rsp_in.saturated = |lane_clip;
         rsp_in.last_out  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/vector_transform_4x4.sv]
// Multiplies each (x, y, z, w) vector beat in signed Q8.8 by a 4x4 matrix of signed
// Q4.12 coefficients. csr_index 0..3 selects the row that produces x_out, y_out, z_out
// or w_out; within a row, bits 15:0 weight x, 31:16 y, 47:32 z and 63:48 w. Other
// indexes are ignored. Reset loads the identity matrix. Each output is rounded half up
// to Q8.8 and clipped to 16 bits; saturated flags any clipped component, and last_out
// repeats last_in. Four lanes of four 16x16 multipliers each work in parallel, so a new
// vector is taken every cycle unless rsp_stall holds the pipeline; each result passes
// one stage for the multipliers, one for the four-term sums, one for rounding, clipping
// and the output register. The user must write rows only while idle; it is unchecked.
module vector_transform_4x4 (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  vt4_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output vt4_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [vt4_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [vt4_pkg::RowW-1:0]        csr_wdata
);

   logic [vt4_pkg::RowW-1:0] coeff_ff [vt4_pkg::NumComp];
   logic [vt4_pkg::RowW-1:0] coeff_in [vt4_pkg::NumComp];

   logic mul_valid_ff, mul_valid_in;
   logic sum_valid_ff, sum_valid_in;
   logic mul_last_ff,  mul_last_in;
   logic sum_last_ff,  sum_last_in;
   logic ready_mul, ready_sum, ready_out;

   vt4_pkg::lane_ctrl_type                           lane_ctrl;
   logic [vt4_pkg::NumComp-1:0][vt4_pkg::CompW-1:0]  lane_result;
   logic [vt4_pkg::NumComp-1:0]                      lane_clip;

   // Coefficient row writes.
   always_comb begin
      for (int i = 0; i < vt4_pkg::NumComp; i++) begin
         coeff_in[i] = coeff_ff[i];
      end
      if (csr_we) begin
         unique case (csr_index)
            vt4_pkg::CSR_OUT_X: coeff_in[0] = csr_wdata;
            vt4_pkg::CSR_OUT_Y: coeff_in[1] = csr_wdata;
            vt4_pkg::CSR_OUT_Z: coeff_in[2] = csr_wdata;
            vt4_pkg::CSR_OUT_W: coeff_in[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff[0] <= vt4_pkg::ResetOutX;
         coeff_ff[1] <= vt4_pkg::ResetOutY;
         coeff_ff[2] <= vt4_pkg::ResetOutZ;
         coeff_ff[3] <= vt4_pkg::ResetOutW;
      end else begin
         for (int i = 0; i < vt4_pkg::NumComp; i++) begin
            coeff_ff[i] <= coeff_in[i];
         end
      end
   end

   // Each stage advances when it is empty or the stage after it can take its beat.
   always_comb begin
      ready_sum    = !sum_valid_ff || ready_out;
      ready_mul    = !mul_valid_ff || ready_sum;
      mul_valid_in = ready_mul ? req_valid : mul_valid_ff;
      mul_last_in  = ready_mul ? req_data.last_in : mul_last_ff;
      sum_valid_in = ready_sum ? mul_valid_ff : sum_valid_ff;
      sum_last_in  = ready_sum ? mul_last_ff : sum_last_ff;
      lane_ctrl.en_mul = ready_mul;
      lane_ctrl.en_sum = ready_sum;
   end

   assign req_stall = !ready_mul;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         sum_valid_ff <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_last_ff <= mul_last_in;
      sum_last_ff <= sum_last_in;
   end

   // One lane per output component.
   for (genvar g = 0; g < vt4_pkg::NumComp; g++) begin : g_lane
      logic signed [vt4_pkg::CompW-1:0] result;

      vt4_lane u_lane (
         .clock  (clock),
         .ctrl   (lane_ctrl),
         .req    (req_data),
         .row    (coeff_ff[g]),
         .result (result),
         .clip   (lane_clip[g])
      );

      assign lane_result[g] = result;
   end

   // Gather the lane results into the output register.
   vt4_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .lanes_valid (sum_valid_ff),
      .last        (sum_last_ff),
      .lane_result (lane_result),
      .lane_clip   (lane_clip),
      .rsp_stall   (rsp_stall),
      .ready       (ready_out),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

[tb/tb_vector_transform_4x4.sv]
module tb_vector_transform_4x4;

   localparam int IdleLimit     = 5000;
   localparam int SettleCycles  = 8;
   localparam int NumPhases     = 8;
   localparam int BeatsPerPhase = 190;

   // Register indexes beyond the last row; writes there must be ignored.
   localparam logic [vt4_pkg::CsrIdxW-1:0] CsrFirstUnused = 3'd4;
   localparam logic [vt4_pkg::CsrIdxW-1:0] CsrLastUnused  = 3'd7;

   localparam logic [vt4_pkg::RowW-1:0] RowAllMax  = {vt4_pkg::NumComp{vt4_pkg::SatMax}};
   localparam logic [vt4_pkg::RowW-1:0] RowAllMin  = {vt4_pkg::NumComp{vt4_pkg::SatMin}};
   localparam logic [vt4_pkg::RowW-1:0] RowAllLsb  = {vt4_pkg::NumComp{16'h0001}};
   localparam logic [vt4_pkg::RowW-1:0] RowAllOnes = '1;
   localparam logic [vt4_pkg::RowW-1:0] RowZero    = '0;

   typedef logic [vt4_pkg::RowW-1:0] matrix_type [vt4_pkg::NumComp];

   // Holds the coefficient rows and the transformed vectors still owed by the block.
   class transform_scoreboard;
      logic [vt4_pkg::RowW-1:0] rows [vt4_pkg::NumComp];
      vt4_pkg::rsp_type         owed_q [$];
      int                       failures;
      int                       beats_checked;

      function new();
         rows[vt4_pkg::CSR_OUT_X] = vt4_pkg::ResetOutX;
         rows[vt4_pkg::CSR_OUT_Y] = vt4_pkg::ResetOutY;
         rows[vt4_pkg::CSR_OUT_Z] = vt4_pkg::ResetOutZ;
         rows[vt4_pkg::CSR_OUT_W] = vt4_pkg::ResetOutW;
         failures = 0;
         beats_checked = 0;
      endfunction

      function void write_row(logic [vt4_pkg::CsrIdxW-1:0] idx,
                              logic [vt4_pkg::RowW-1:0] data);
         if (idx <= vt4_pkg::CSR_OUT_W) rows[int'(idx)] = data;
      endfunction

      // Each output is a full-width dot product, rounded half up to Q8.8 and clipped.
      function vt4_pkg::rsp_type transform(vt4_pkg::req_type v);
         longint  comp [vt4_pkg::NumComp];
         longint  acc;
         longint  rounded;
         vt4_pkg::rsp_type r;
         logic [vt4_pkg::CompW-1:0] res [vt4_pkg::NumComp];
         logic    clip;
         clip = 1'b0;
         comp[0] = $signed(v.x_in);
         comp[1] = $signed(v.y_in);
         comp[2] = $signed(v.z_in);
         comp[3] = $signed(v.w_in);
         for (int i = 0; i < vt4_pkg::NumComp; i++) begin
            acc = 0;
            for (int k = 0; k < vt4_pkg::NumComp; k++)
               acc += comp[k] *
                      longint'($signed(rows[i][vt4_pkg::CoeffW*k +: vt4_pkg::CoeffW]));
            rounded = (acc + (longint'(1) <<< (vt4_pkg::FracShift - 1))) >>>
                      vt4_pkg::FracShift;
            if (rounded > longint'(vt4_pkg::SatMax)) begin
               rounded = longint'(vt4_pkg::SatMax);
               clip = 1'b1;
            end else if (rounded < longint'(vt4_pkg::SatMin)) begin
               rounded = longint'(vt4_pkg::SatMin);
               clip = 1'b1;
            end
            res[i] = rounded[vt4_pkg::CompW-1:0];
         end
         r.x_out = res[0];
         r.y_out = res[1];
         r.z_out = res[2];
         r.w_out = res[3];
         r.saturated = clip;
         r.last_out = v.last_in;
         return r;
      endfunction

      function void note_vector(vt4_pkg::req_type v);
         owed_q.push_back(transform(v));
      endfunction

      function int owed();
         return owed_q.size();
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         failures++;
      endtask

      task compare_field(string name, logic [vt4_pkg::CompW-1:0] got,
                         logic [vt4_pkg::CompW-1:0] want);
         if (got !== want)
            report($sformatf("result beat %0d, %s: got %h, expected %h",
                             beats_checked, name, got, want));
      endtask

      task check_result(vt4_pkg::rsp_type got);
         vt4_pkg::rsp_type want;
         if (owed_q.size() == 0) begin
            report($sformatf("result beat %0d arrived with nothing owed: %h",
                             beats_checked, got));
         end else begin
            want = owed_q.pop_front();
            compare_field("x_out", got.x_out, want.x_out);
            compare_field("y_out", got.y_out, want.y_out);
            compare_field("z_out", got.z_out, want.z_out);
            compare_field("w_out", got.w_out, want.w_out);
            compare_field("saturated", vt4_pkg::CompW'(got.saturated),
                          vt4_pkg::CompW'(want.saturated));
            compare_field("last_out", vt4_pkg::CompW'(got.last_out),
                          vt4_pkg::CompW'(want.last_out));
         end
         beats_checked++;
      endtask

      task check_drained();
         if (owed_q.size() != 0)
            report($sformatf("%0d result beats never arrived", owed_q.size()));
      endtask
   endclass

   logic                         clock;
   logic                         reset      = 1'b1;
   logic                         req_valid  = 1'b0;
   logic                         req_stall;
   vt4_pkg::req_type             req_data   = '0;
   logic                         rsp_valid;
   logic                         rsp_stall  = 1'b0;
   vt4_pkg::rsp_type             rsp_data;
   logic                         csr_we     = 1'b0;
   logic [vt4_pkg::CsrIdxW-1:0]  csr_index  = '0;
   logic [vt4_pkg::RowW-1:0]     csr_wdata  = '0;

   transform_scoreboard sb = new();
   bit                  quiet = 1'b0;
   int                  stall_left = 0;
   int                  idle_cycles = 0;

   vector_transform_4x4 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Sample every handshake and register write at the rising edge, inputs first.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.write_row(csr_index, csr_wdata);
         if (req_valid && !req_stall) sb.note_vector(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // End the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IdleLimit) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Result-side back pressure: mostly short stalls, a few long ones, none when quiet.
   always @(negedge clock) begin
      int r;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
         stall_left <= 4;
      end else begin
         r = $urandom_range(99);
         if (r < 55) begin
            rsp_stall <= 1'b0;
            stall_left <= $urandom_range(6);
         end else if (r < 90) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(3, 1);
         end else begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(40, 10);
         end
      end
   end

   function automatic int gap_cycles();
      int r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic vt4_pkg::req_type make_vector(logic [vt4_pkg::CompW-1:0] x,
                                                    logic [vt4_pkg::CompW-1:0] y,
                                                    logic [vt4_pkg::CompW-1:0] z,
                                                    logic [vt4_pkg::CompW-1:0] w,
                                                    logic last);
      vt4_pkg::req_type v;
      v.x_in = x;
      v.y_in = y;
      v.z_in = z;
      v.w_in = w;
      v.last_in = last;
      return v;
   endfunction

   // Mostly full-range values, with extremes and small magnitudes mixed in.
   function automatic logic [vt4_pkg::CompW-1:0] rand_comp();
      int r;
      r = $urandom_range(99);
      if (r < 10) begin
         case ($urandom_range(3))
            0: return vt4_pkg::SatMax;
            1: return vt4_pkg::SatMin;
            2: return '0;
            default: return '1;
         endcase
      end
      if (r < 30) return vt4_pkg::CompW'($urandom_range(1024) - 512);
      return vt4_pkg::CompW'($urandom);
   endfunction

   function automatic logic [vt4_pkg::RowW-1:0] rand_row(int idx);
      logic [vt4_pkg::RowW-1:0] row;
      logic [vt4_pkg::RowW-1:0] resets [vt4_pkg::NumComp];
      resets[vt4_pkg::CSR_OUT_X] = vt4_pkg::ResetOutX;
      resets[vt4_pkg::CSR_OUT_Y] = vt4_pkg::ResetOutY;
      resets[vt4_pkg::CSR_OUT_Z] = vt4_pkg::ResetOutZ;
      resets[vt4_pkg::CSR_OUT_W] = vt4_pkg::ResetOutW;
      case ($urandom_range(4))
         0, 1: row = {$urandom, $urandom};
         2: begin
            for (int k = 0; k < vt4_pkg::NumComp; k++)
               row[vt4_pkg::CoeffW*k +: vt4_pkg::CoeffW] =
                  vt4_pkg::CoeffW'($urandom_range(8192) - 4096);
         end
         3: begin
            case ($urandom_range(3))
               0: row = RowAllMax;
               1: row = RowAllMin;
               2: row = RowZero;
               default: row = RowAllOnes;
            endcase
         end
         default: row = resets[idx];
      endcase
      return row;
   endfunction

   // Present one vector beat after an optional gap; returns at the falling edge after acceptance.
   task automatic send_vector(vt4_pkg::req_type v);
      int gap;
      gap = gap_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop sending and let every owed result come out before touching the rows.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.owed() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      @(negedge clock);
   endtask

   // Load all four rows back to back, optionally followed by a write to an unused index.
   task automatic write_matrix(matrix_type m, bit with_unused);
      for (int i = vt4_pkg::CSR_OUT_X; i <= vt4_pkg::CSR_OUT_W; i++) begin
         csr_we <= 1'b1;
         csr_index <= vt4_pkg::CsrIdxW'(i);
         csr_wdata <= m[i];
         @(negedge clock);
      end
      if (with_unused) begin
         csr_we <= 1'b1;
         csr_index <= vt4_pkg::CsrIdxW'($urandom_range(CsrLastUnused, CsrFirstUnused));
         csr_wdata <= {$urandom, $urandom};
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      matrix_type       m;
      vt4_pkg::req_type v;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Identity matrix from reset: values pass through unchanged.
      send_vector(make_vector('0, '0, '0, '0, 1'b0));
      send_vector(make_vector(vt4_pkg::SatMax, vt4_pkg::SatMax, vt4_pkg::SatMax,
                              vt4_pkg::SatMax, 1'b1));
      send_vector(make_vector(vt4_pkg::SatMin, vt4_pkg::SatMin, vt4_pkg::SatMin,
                              vt4_pkg::SatMin, 1'b0));
      send_vector(make_vector(vt4_pkg::SatMax, vt4_pkg::SatMin, 16'h0001, 16'hFFFF, 1'b1));
      send_vector(make_vector(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 1'b0));
      wait_drained();

      // Largest positive coefficients drive both directions into saturation.
      for (int i = 0; i < vt4_pkg::NumComp; i++) m[i] = RowAllMax;
      write_matrix(m, 1'b0);
      send_vector(make_vector(vt4_pkg::SatMax, vt4_pkg::SatMax, vt4_pkg::SatMax,
                              vt4_pkg::SatMax, 1'b0));
      send_vector(make_vector(vt4_pkg::SatMin, vt4_pkg::SatMin, vt4_pkg::SatMin,
                              vt4_pkg::SatMin, 1'b1));
      send_vector(make_vector(vt4_pkg::SatMax, vt4_pkg::SatMin, vt4_pkg::SatMax,
                              vt4_pkg::SatMin, 1'b0));
      send_vector(make_vector(16'h0001, '0, '0, '0, 1'b1));
      wait_drained();

      // Most negative coefficients: the largest product sum of all.
      for (int i = 0; i < vt4_pkg::NumComp; i++) m[i] = RowAllMin;
      write_matrix(m, 1'b0);
      send_vector(make_vector(vt4_pkg::SatMin, vt4_pkg::SatMin, vt4_pkg::SatMin,
                              vt4_pkg::SatMin, 1'b0));
      send_vector(make_vector(vt4_pkg::SatMax, vt4_pkg::SatMax, vt4_pkg::SatMax,
                              vt4_pkg::SatMax, 1'b1));
      send_vector(make_vector(vt4_pkg::SatMin, vt4_pkg::SatMax, '0, '0, 1'b0));
      wait_drained();

      // Coefficients of one LSB expose rounding, ties going toward plus infinity.
      // A write to an unused index in between must leave the rows alone.
      for (int i = 0; i < vt4_pkg::NumComp; i++) m[i] = RowAllLsb;
      write_matrix(m, 1'b1);
      send_vector(make_vector(16'd2048, '0, '0, '0, 1'b0));
      send_vector(make_vector(-16'sd2048, '0, '0, '0, 1'b1));
      send_vector(make_vector(16'd6144, '0, '0, '0, 1'b0));
      send_vector(make_vector(-16'sd6144, '0, '0, '0, 1'b1));
      send_vector(make_vector(16'd2047, '0, '0, '0, 1'b0));
      send_vector(make_vector(16'd1024, 16'd1024, '0, '0, 1'b1));
      wait_drained();

      // Random phases, each under a fresh matrix; some phases run without any idling.
      for (int phase = 0; phase < NumPhases; phase++) begin
         for (int i = 0; i < vt4_pkg::NumComp; i++) begin
            if (phase == 0) m[i] = RowZero;
            else if (phase == 1) m[i] = RowAllOnes;
            else m[i] = rand_row(i);
         end
         write_matrix(m, bit'($urandom_range(1)));
         quiet = (phase % 3 == 2);
         for (int n = 0; n < BeatsPerPhase; n++) begin
            v = make_vector(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                            ($urandom_range(7) == 0));
            send_vector(v);
         end
         wait_drained();
      end
      quiet = 1'b0;

      sb.check_drained();
      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/vt4_pkg.sv
sv/vt4_lane.sv
sv/vt4_merge.sv
sv/vector_transform_4x4.sv
tb/tb_vector_transform_4x4.sv
